FILE: design/gpl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gradient palette lookup package
// Shared constants, controller states and the command / status words that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package gpl_pkg;

    // default palette depth
    localparam int PALETTE_ENTRIES_DEF = 16;

    // operation codes of an input word
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // colour channels, in the order they are worked
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam int         NUM_CH   = 3;

    // quotient bits of the blend divide (quotient never exceeds 255)
    localparam int          DIV_STEPS = 8;
    localparam logic [2:0]  DIV_LAST  = 3'(DIV_STEPS - 1);

    // full-scale brightness
    localparam logic [7:0]  FULL_SCALE = 8'd255;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE,
        ST_MUL,
        ST_DIV,
        ST_SCALE_MUL,
        ST_SCALE_Q,
        ST_SCALE_FIX,
        ST_DONE
    } gpl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // write one palette stop
        logic start;      // latch a lookup word, clear the scan
        logic scan;       // one step of the stop scan
        logic resolve;    // settle missing sides, form the fraction
        logic mul;        // channel difference times numerator
        logic div_step;   // one restoring divide step
        logic scale_mul;  // blended value times brightness
        logic scale_q;    // quotient estimate of the /255
        logic scale_fix;  // correct the estimate, store the channel
        logic publish;    // move the colour to the output register
    } gpl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic div_last;
        logic last_ch;
        logic out_free;
    } gpl_stat_t;

    // pick one 8-bit channel out of a packed RGB colour
    function automatic logic [7:0] chan_sel(input logic [23:0] colour,
                                            input logic [1:0]  ch);
        logic [7:0] res;
        case (ch)
            CH_RED:   res = colour[23:16];
            CH_GREEN: res = colour[15:8];
            CH_BLUE:  res = colour[7:0];
            default:  res = colour[7:0];
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: design/gpl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gradient palette lookup controller
// Sequences a lookup through stop scan, side resolution and three passes of
// multiply, serial divide and brightness scaling, then hands the colour on.
// ----------------------------------------------------------------------------
module gpl_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              op,
    input  wire gpl_pkg::gpl_stat_t stat,
    output gpl_pkg::gpl_cmd_t      cmd
);
    import gpl_pkg::*;

    gpl_state_t state_reg;
    gpl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (op == OP_LOOKUP))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:   state_next = ST_MUL;
            ST_MUL:       state_next = ST_DIV;
            ST_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = ST_SCALE_MUL;
                end
            end
            ST_SCALE_MUL: state_next = ST_SCALE_Q;
            ST_SCALE_Q:   state_next = ST_SCALE_FIX;
            ST_SCALE_FIX: state_next = stat.last_ch ? ST_DONE : ST_MUL;
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.load  = in_valid && (op == OP_LOAD);
                cmd.start = in_valid && (op == OP_LOOKUP);
            end
            ST_SCAN:      cmd.scan      = 1'b1;
            ST_RESOLVE:   cmd.resolve   = 1'b1;
            ST_MUL:       cmd.mul       = 1'b1;
            ST_DIV:       cmd.div_step  = 1'b1;
            ST_SCALE_MUL: cmd.scale_mul = 1'b1;
            ST_SCALE_Q:   cmd.scale_q   = 1'b1;
            ST_SCALE_FIX: cmd.scale_fix = 1'b1;
            ST_DONE:      cmd.publish   = stat.out_free;
            default:      cmd           = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: design/gpl_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gradient palette lookup datapath
// Stop memories, scan registers, the 8-step restoring divider, the exact
// divide-by-255 for brightness scaling and the output register.
// ----------------------------------------------------------------------------
module gpl_datapath #(
    parameter int PALETTE_ENTRIES = gpl_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gpl_pkg::gpl_cmd_t cmd,
    output gpl_pkg::gpl_stat_t     stat,
    // configuration
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [4:0]        stop_count,
    // input word payload
    input  wire logic [3:0]        slot,
    input  wire logic [7:0]        stop_position,
    input  wire logic [7:0]        stop_red,
    input  wire logic [7:0]        stop_green,
    input  wire logic [7:0]        stop_blue,
    input  wire logic [7:0]        grad_index,
    input  wire logic [7:0]        brightness,
    // result channel
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             red_out,
    output logic [7:0]             green_out,
    output logic [7:0]             blue_out
);
    import gpl_pkg::*;

    localparam int ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(PALETTE_ENTRIES + 1);

    // stop memories, undefined until written
    logic [7:0]  pos_mem [PALETTE_ENTRIES];
    logic [23:0] col_mem [PALETTE_ENTRIES];

    // control registers
    logic [4:0]       stop_count_reg,   stop_count_next;
    logic [CNT_W-1:0] count_reg,        count_next;
    logic [CNT_W-1:0] scan_cnt_reg,     scan_cnt_next;
    logic             rd_vld_reg,       rd_vld_next;
    logic             have_lo_reg,      have_lo_next;
    logic             have_hi_reg,      have_hi_next;
    logic [1:0]       ch_reg,           ch_next;
    logic [2:0]       div_cnt_reg,      div_cnt_next;
    logic             out_valid_reg,    out_valid_next;

    // payload registers
    logic [7:0]  idx_reg,    idx_next;
    logic [7:0]  bright_reg, bright_next;
    logic [7:0]  rd_pos_reg;
    logic [23:0] rd_col_reg;
    logic [7:0]  plo_reg,    plo_next;
    logic [7:0]  phi_reg,    phi_next;
    logic [23:0] clo_reg,    clo_next;
    logic [23:0] chi_reg,    chi_next;
    logic [7:0]  num_reg,    num_next;
    logic [7:0]  den_reg,    den_next;
    logic        neg_reg,    neg_next;
    logic [7:0]  lo_ch_reg,  lo_ch_next;
    logic [7:0]  rem_reg,    rem_next;
    logic [7:0]  quo_reg,    quo_next;
    logic [15:0] x_reg,      x_next;
    logic [7:0]  q0_reg,     q0_next;
    logic [7:0]  res_reg  [NUM_CH];
    logic [7:0]  res_next [NUM_CH];
    logic [7:0]  red_reg,    red_next;
    logic [7:0]  green_reg,  green_next;
    logic [7:0]  blue_reg,   blue_next;

    // memory port controls
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    // combinational helpers
    logic [7:0]  lo_p, hi_p;
    logic [23:0] lo_c, hi_c;
    logic [7:0]  lo8, hi8, mag;
    logic [15:0] prod;
    logic [8:0]  trial, trial_sub;
    logic        ge;
    logic [7:0]  q_blend, v8;
    logic [16:0] est_sum;
    logic [15:0] q0_x255, rem255;

    assign wr_en   = cmd.load && (32'(slot) < PALETTE_ENTRIES);
    assign wr_addr = ADDR_W'(slot);
    assign rd_en   = cmd.scan && (scan_cnt_reg < count_reg);
    assign rd_addr = scan_cnt_reg[ADDR_W-1:0];

    // stop memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_mem[wr_addr] <= stop_position;
            col_mem[wr_addr] <= {stop_red, stop_green, stop_blue};
        end
        if (rd_en)
        begin
            rd_pos_reg <= pos_mem[rd_addr];
            rd_col_reg <= col_mem[rd_addr];
        end
    end

    // side resolution: a missing side copies the other
    always_comb
    begin
        lo_p = have_lo_reg ? plo_reg : phi_reg;
        lo_c = have_lo_reg ? clo_reg : chi_reg;
        hi_p = have_hi_reg ? phi_reg : lo_p;
        hi_c = have_hi_reg ? chi_reg : lo_c;
    end

    // channel difference and product
    always_comb
    begin
        lo8  = chan_sel(clo_reg, ch_reg);
        hi8  = chan_sel(chi_reg, ch_reg);
        mag  = (hi8 < lo8) ? (lo8 - hi8) : (hi8 - lo8);
        prod = {8'd0, mag} * {8'd0, num_reg};
    end

    // restoring divide step
    always_comb
    begin
        trial     = {rem_reg, quo_reg[7]};
        trial_sub = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});
    end

    // blend and brightness scaling; x/255 estimate is low by at most one
    always_comb
    begin
        q_blend = (den_reg == 8'd0) ? 8'd0 : quo_reg;
        v8      = neg_reg ? (lo_ch_reg - q_blend) : (lo_ch_reg + q_blend);
        est_sum = {1'b0, x_reg} + {9'd0, x_reg[15:8]};
        q0_x255 = {q0_reg, 8'd0} - {8'd0, q0_reg};
        rem255  = x_reg - q0_x255;
    end

    // next-state logic
    always_comb
    begin
        stop_count_next   = stop_count_reg;
        count_next        = count_reg;
        scan_cnt_next     = scan_cnt_reg;
        rd_vld_next       = 1'b0;
        have_lo_next      = have_lo_reg;
        have_hi_next      = have_hi_reg;
        ch_next           = ch_reg;
        div_cnt_next      = div_cnt_reg;
        out_valid_next    = out_valid_reg;
        idx_next          = idx_reg;
        bright_next       = bright_reg;
        plo_next          = plo_reg;
        phi_next          = phi_reg;
        clo_next          = clo_reg;
        chi_next          = chi_reg;
        num_next          = num_reg;
        den_next          = den_reg;
        neg_next          = neg_reg;
        lo_ch_next        = lo_ch_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        x_next            = x_reg;
        q0_next           = q0_reg;
        res_next          = res_reg;
        red_next          = red_reg;
        green_next        = green_reg;
        blue_next         = blue_reg;

        // configuration write
        if (cfg_valid)
        begin
            stop_count_next = stop_count;
        end

        // new lookup: latch word, clamp stop count, clear scan
        if (cmd.start)
        begin
            idx_next      = grad_index;
            bright_next   = brightness;
            count_next    = (32'(stop_count_reg) > PALETTE_ENTRIES)
                            ? CNT_W'(PALETTE_ENTRIES) : CNT_W'(stop_count_reg);
            scan_cnt_next = '0;
            have_lo_next  = 1'b0;
            have_hi_next  = 1'b0;
            plo_next      = 8'd0;
            phi_next      = 8'd255;
            clo_next      = '0;
            chi_next      = '0;
            ch_next       = CH_RED;
        end

        // stop scan: issue a read, fold in the one that came back
        if (cmd.scan)
        begin
            if (rd_en)
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                rd_vld_next   = 1'b1;
            end
            if (rd_vld_reg)
            begin
                if (rd_pos_reg <= idx_reg)
                begin
                    have_lo_next = 1'b1;
                    plo_next     = rd_pos_reg;
                    clo_next     = rd_col_reg;
                end
                if ((rd_pos_reg >= idx_reg) && !have_hi_reg)
                begin
                    have_hi_next = 1'b1;
                    phi_next     = rd_pos_reg;
                    chi_next     = rd_col_reg;
                end
            end
        end

        // settle both sides and the interpolation fraction
        if (cmd.resolve)
        begin
            plo_next = lo_p;
            phi_next = hi_p;
            clo_next = lo_c;
            chi_next = hi_c;
            if ((hi_p > lo_p) && (idx_reg >= lo_p))
            begin
                num_next = idx_reg - lo_p;
                den_next = hi_p - lo_p;
            end
            else
            begin
                num_next = 8'd0;
                den_next = 8'd0;
            end
        end

        // |hi - lo| * num loads the divider; top byte is below den
        if (cmd.mul)
        begin
            neg_next     = (hi8 < lo8);
            lo_ch_next   = lo8;
            rem_next     = prod[15:8];
            quo_next     = prod[7:0];
            div_cnt_next = '0;
        end

        if (cmd.div_step)
        begin
            rem_next     = ge ? trial_sub[7:0] : trial[7:0];
            quo_next     = {quo_reg[6:0], ge};
            div_cnt_next = div_cnt_reg + 1'b1;
        end

        if (cmd.scale_mul)
        begin
            x_next = {8'd0, v8} * {8'd0, bright_reg};
        end

        if (cmd.scale_q)
        begin
            q0_next = est_sum[15:8];
        end

        if (cmd.scale_fix)
        begin
            res_next[ch_reg] = (rem255 >= {8'd0, FULL_SCALE}) ? (q0_reg + 8'd1) : q0_reg;
            ch_next          = (ch_reg == CH_BLUE) ? CH_RED : (ch_reg + 2'd1);
        end

        // output register
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
            red_next       = res_reg[CH_RED];
            green_next     = res_reg[CH_GREEN];
            blue_next      = res_reg[CH_BLUE];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_reg   <= '0;
            count_reg        <= '0;
            scan_cnt_reg     <= '0;
            rd_vld_reg       <= 1'b0;
            have_lo_reg      <= 1'b0;
            have_hi_reg      <= 1'b0;
            ch_reg           <= CH_RED;
            div_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            stop_count_reg   <= stop_count_next;
            count_reg        <= count_next;
            scan_cnt_reg     <= scan_cnt_next;
            rd_vld_reg       <= rd_vld_next;
            have_lo_reg      <= have_lo_next;
            have_hi_reg      <= have_hi_next;
            ch_reg           <= ch_next;
            div_cnt_reg      <= div_cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        bright_reg <= bright_next;
        plo_reg    <= plo_next;
        phi_reg    <= phi_next;
        clo_reg    <= clo_next;
        chi_reg    <= chi_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        neg_reg    <= neg_next;
        lo_ch_reg  <= lo_ch_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        x_reg      <= x_next;
        q0_reg     <= q0_next;
        res_reg    <= res_next;
        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
    end

    // status and ports
    assign stat.scan_done = (scan_cnt_reg == count_reg) && !rd_vld_reg;
    assign stat.div_last  = (div_cnt_reg == DIV_LAST);
    assign stat.last_ch   = (ch_reg == CH_BLUE);
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

    // checks
    ap_rd_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> $past(cmd.scan))
        else $error("read data valid without a scan step");

    ap_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_cnt_reg <= count_reg)
        else $error("scan ran past the stops in use");

    ap_fraction: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(cmd.resolve) && (den_reg != 8'd0)) |-> (num_reg <= den_reg))
        else $error("blend fraction above one, divider would overflow");

    ap_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || out_ready))
        else $error("colour published over a word not yet taken");

endmodule
`default_nettype wire

FILE: design/gradient_palette_lookup_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gradient palette lookup unit
// Gradient palette of up to PALETTE_ENTRIES stops with linear interpolation
// between the stops around an index and exact brightness scaling.
// ----------------------------------------------------------------------------
// A load word (op 0) writes one stop; slots at or above PALETTE_ENTRIES
// are dropped. A lookup word (op 1) scans the N stops in use (stop_count,
// limited to PALETTE_ENTRIES) through the single registered read port of
// the stop memory; a resolve step then settles the two sides, each of the
// three channels passes in turn through the shared multiplier, the 8-step
// restoring divider and the two-step divide by 255, and a publish step
// hands the colour to the output register once that register is free. One
// lookup is in flight at a time; the next word is taken while a finished
// colour still waits in the output register. Stops must be written before
// a lookup uses them. The user must see that stop_count is written through
// the configuration port only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module gradient_palette_lookup_unit #(
    parameter int PALETTE_ENTRIES = gpl_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [4:0] stop_count,
    // input words
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       op,
    input  wire logic [3:0] slot,
    input  wire logic [7:0] stop_position,
    input  wire logic [7:0] stop_red,
    input  wire logic [7:0] stop_green,
    input  wire logic [7:0] stop_blue,
    input  wire logic [7:0] grad_index,
    input  wire logic [7:0] brightness,
    // result words
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      red_out,
    output logic [7:0]      green_out,
    output logic [7:0]      blue_out
);
    import gpl_pkg::*;

    gpl_cmd_t  cmd;
    gpl_stat_t stat;

    // sequencer
    gpl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .stat     (stat),
        .cmd      (cmd)
    );

    // memories and arithmetic
    gpl_datapath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .stop_count    (stop_count),
        .slot          (slot),
        .stop_position (stop_position),
        .stop_red      (stop_red),
        .stop_green    (stop_green),
        .stop_blue     (stop_blue),
        .grad_index    (grad_index),
        .brightness    (brightness),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .red_out       (red_out),
        .green_out     (green_out),
        .blue_out      (blue_out)
    );

endmodule
`default_nettype wire

FILE: dv/gradient_palette_lookup_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient palette lookup unit testbench
// Drives load and lookup words through the valid/ready input channel. A
// local palette model predicts every lookup colour, and the monitor checks
// each result word in order. stop_count is reprogrammed between phases,
// always while the unit is idle.
// ----------------------------------------------------------------------------
module gradient_palette_lookup_unit_tb;

    import gpl_pkg::*;

    localparam int STOPS      = PALETTE_ENTRIES_DEF;
    localparam int SETTLE     = 64;       // covers the longest lookup
    localparam int PHASE_LEN  = 130;

    typedef struct packed {
        logic       op;
        logic [3:0] slot;
        logic [7:0] pos;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] idx;
        logic [7:0] bright;
    } word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [4:0] cfg_size = 5'd0;

    logic  in_valid = 1'b0;
    logic  in_ready;
    word_t cur_word = '0;

    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;

    // palette copy and its size, as the unit should hold them
    logic [7:0]  stop_pos [STOPS];
    logic [23:0] stop_rgb [STOPS];
    int          size_now = 0;

    word_t pending_words [$];
    rgb_t  colour_q [$];
    int    errors = 0;
    bit    idle_on = 1'b1;
    logic [4:0] in_gap = '0;
    logic [4:0] out_stall = '0;

    always #5 clk = ~clk;

    gradient_palette_lookup_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .stop_count    (cfg_size),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (cur_word.op),
        .slot          (cur_word.slot),
        .stop_position (cur_word.pos),
        .stop_red      (cur_word.red),
        .stop_green    (cur_word.green),
        .stop_blue     (cur_word.blue),
        .grad_index    (cur_word.idx),
        .brightness    (cur_word.bright),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .red_out       (red_out),
        .green_out     (green_out),
        .blue_out      (blue_out)
    );

    // one channel: linear blend, then brightness scale with truncation
    function automatic logic [7:0] blend_chan(int lo, int hi, int num, int den, int bright);
        int v;
        v = lo;
        if (den != 0)
            v = v + ((hi - lo) * num) / den;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'((v * bright) / 255);
    endfunction

    // colour the palette gives for an index at a brightness
    function automatic rgb_t palette_colour(logic [7:0] idx, logic [7:0] bright);
        int          n;
        bit          got_lo;
        bit          got_hi;
        int          plo;
        int          phi;
        int          num;
        int          den;
        logic [23:0] clo;
        logic [23:0] chi;
        rgb_t        c;
        n = (size_now > STOPS) ? STOPS : size_now;
        c = '0;
        if (n == 0)
            return c;
        got_lo = 1'b0;
        got_hi = 1'b0;
        plo = 0;
        phi = 255;
        clo = '0;
        chi = '0;
        // last stop at or below, first stop at or above
        for (int i = 0; i < n; i++)
        begin
            if (stop_pos[i] <= idx)
            begin
                got_lo = 1'b1;
                plo = stop_pos[i];
                clo = stop_rgb[i];
            end
            if (stop_pos[i] >= idx && !got_hi)
            begin
                got_hi = 1'b1;
                phi = stop_pos[i];
                chi = stop_rgb[i];
            end
        end
        if (!got_lo)
        begin
            plo = phi;
            clo = chi;
        end
        if (!got_hi)
        begin
            phi = plo;
            chi = clo;
        end
        num = 0;
        den = 0;
        if (phi > plo && idx >= plo)
        begin
            num = idx - plo;
            den = phi - plo;
        end
        c.red   = blend_chan(clo[23:16], chi[23:16], num, den, bright);
        c.green = blend_chan(clo[15:8],  chi[15:8],  num, den, bright);
        c.blue  = blend_chan(clo[7:0],   chi[7:0],   num, den, bright);
        return c;
    endfunction

    // extremes are favoured so duplicates and full-scale cases turn up
    function automatic logic [7:0] pick8();
        case ($urandom_range(0, 4))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(0, 7) * 32);
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic word_t any_word();
        word_t w;
        w.op     = 1'($urandom);
        w.slot   = 4'($urandom);
        w.pos    = 8'($urandom);
        w.red    = 8'($urandom);
        w.green  = 8'($urandom);
        w.blue   = 8'($urandom);
        w.idx    = 8'($urandom);
        w.bright = 8'($urandom);
        return w;
    endfunction

    function automatic word_t load_word(int s, logic [7:0] p, logic [23:0] rgb);
        word_t w;
        w = any_word();
        w.op    = OP_LOAD;
        w.slot  = 4'(s);
        w.pos   = p;
        {w.red, w.green, w.blue} = rgb;
        return w;
    endfunction

    function automatic word_t lookup_word(logic [7:0] i, logic [7:0] b);
        word_t w;
        w = any_word();
        w.op     = OP_LOOKUP;
        w.idx    = i;
        w.bright = b;
        return w;
    endfunction

    // random word; loads lean towards the slots in use
    function automatic word_t random_word();
        word_t w;
        int    lim;
        lim = (size_now > STOPS) ? STOPS : ((size_now < 1) ? 1 : size_now);
        w = any_word();
        if ($urandom_range(0, 3) == 0)
        begin
            w.op = OP_LOAD;
            if ($urandom_range(0, 1) != 0)
                w.slot = 4'($urandom_range(0, lim - 1));
            w.pos   = pick8();
            w.red   = pick8();
            w.green = pick8();
            w.blue  = pick8();
        end
        else
        begin
            w.op     = OP_LOOKUP;
            w.idx    = pick8();
            w.bright = pick8();
        end
        return w;
    endfunction

    task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // input driver: takes words from the pending queue, idles in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cur_word <= '0;
            in_gap   <= '0;
        end
        else
        begin
            // accepted word updates the palette copy or yields a colour
            if (in_valid && in_ready)
            begin
                if (cur_word.op == OP_LOAD)
                begin
                    if (cur_word.slot < STOPS)
                    begin
                        stop_pos[cur_word.slot] = cur_word.pos;
                        stop_rgb[cur_word.slot] = {cur_word.red, cur_word.green,
                                                   cur_word.blue};
                    end
                end
                else
                    colour_q.push_back(palette_colour(cur_word.idx, cur_word.bright));
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap != 0)
                begin
                    in_gap   <= in_gap - 1'b1;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0 && idle_on && $urandom_range(0, 5) == 0)
                begin
                    in_gap   <= 5'($urandom_range(0, 16));
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    cur_word <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall <= '0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (colour_q.size() == 0)
                begin
                    $display("%0t: unexpected colour word, expected none actual %0d %0d %0d",
                             $time, red_out, green_out, blue_out);
                    errors++;
                end
                else
                begin
                    rgb_t exp_c;
                    exp_c = colour_q.pop_front();
                    check_field("red_out",   exp_c.red,   red_out);
                    check_field("green_out", exp_c.green, green_out);
                    check_field("blue_out",  exp_c.blue,  blue_out);
                end
            end
            if (out_stall != 0)
            begin
                out_stall <= out_stall - 1'b1;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 5'($urandom_range(0, 16));
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // wait for every word and colour to pass, then let the unit settle
    task automatic drain();
        while (pending_words.size() != 0 || in_valid || colour_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_size(int v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_size  <= 5'(v);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_now = v;
    endtask

    // stimulus
    initial
    begin
        int sizes [8];
        sizes = '{16, 1, 2, 31, 0, 17, 0, 16};
        sizes[6] = $urandom_range(3, 15);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty palette straight out of reset
        pending_words.push_back(lookup_word(8'd0, 8'd255));
        pending_words.push_back(lookup_word(8'd255, 8'd255));

        // fill every slot before any lookup uses one; slot 8 repeats slot 7
        for (int s = 0; s < STOPS; s++)
        begin
            logic [23:0] rgb;
            rgb = {pick8(), pick8(), pick8()};
            if (s == 0)
                rgb = 24'hFF00FF;
            if (s == STOPS - 1)
                rgb = 24'h00FF00;
            pending_words.push_back(load_word(s, (s == 8) ? 8'd119 : 8'(s * 17), rgb));
        end
        drain();

        write_size(STOPS);
        pending_words.push_back(lookup_word(8'd0, 8'd255));    // exactly on a stop
        pending_words.push_back(lookup_word(8'd255, 8'd255));  // top stop
        pending_words.push_back(lookup_word(8'd9, 8'd255));    // between two stops
        pending_words.push_back(lookup_word(8'd119, 8'd128));  // two stops share a position
        pending_words.push_back(lookup_word(8'd200, 8'd0));    // zero brightness
        pending_words.push_back(lookup_word(8'd130, 8'd1));
        drain();

        // random phases, one palette size each; the last runs without idling
        for (int ph = 0; ph < 8; ph++)
        begin
            write_size(sizes[ph]);
            if (ph == 7)
                idle_on = 1'b0;
            for (int n = 0; n < PHASE_LEN; n++)
                pending_words.push_back(random_word());
            drain();
        end

        if (errors == 0)
            $display("gradient_palette_lookup_unit_tb: clean");
        else
            $display("gradient_palette_lookup_unit_tb: errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("gradient_palette_lookup_unit_tb: errors");
        $finish;
    end

endmodule
